/* rtl/core/odl_pkg.sv */
// Shared types and constants of the ordered delimiter locator.
// Depends on nothing; used by the interfaces, controller, datapath and top level.
package odl_pkg;

    // Field widths fixed by the channel formats.
    localparam int BYTE_W   = 8;
    localparam int SLOT_W   = 3;
    localparam int POS_W    = 16;
    localparam int LEN_W    = 15;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_TOTAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_BYTES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_MISSING = 3'd4;

    // Configuration reset values.
    localparam logic [CNT_W-1:0]      RST_TOKEN_TOTAL = 4'd8;
    localparam logic [LEN_W-1:0]      RST_SCAN_LIMIT  = 15'h7FFF;

    // Marker of a slot that holds no position (-1).
    localparam logic [POS_W-1:0] POS_NONE = 16'hFFFF;

    // Result kinds.
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_MAP  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;         // an input request is taken this cycle
        logic drain_start;  // rewind the map index
        logic drain_next;   // advance the map index
        logic show_map;     // output register presents a map entry
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic live;         // the taken byte belongs to an active scan
        logic done;         // the taken byte ends the scan
        logic drain_last;   // map index points at the final slot in use
    } t_sts;

endpackage

/* rtl/core/odl_ifs.sv */
// Handshake channel interfaces of the ordered delimiter locator.
// Depends on odl_pkg for the field widths.

// Input byte channel.
interface odl_in_if;
    logic                            valid;
    logic                            ready;
    logic [odl_pkg::BYTE_W-1:0]      byte_in;
    logic                            first_byte;

    modport source (output valid, output byte_in, output first_byte, input ready);
    modport sink   (input valid, input byte_in, input first_byte, output ready);
endinterface

// Result channel.
interface odl_out_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [odl_pkg::BYTE_W-1:0]      byte_out;
    logic [odl_pkg::SLOT_W-1:0]      token_slot;
    logic signed [odl_pkg::POS_W-1:0] position;
    logic [odl_pkg::LEN_W-1:0]       scan_length;
    logic                            last;

    modport source (output valid, output kind, output byte_out, output token_slot,
                    output position, output scan_length, output last, input ready);
    modport sink   (input valid, input kind, input byte_out, input token_slot,
                    input position, input scan_length, input last, output ready);
endinterface

// Configuration write channel.
interface odl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [odl_pkg::CFG_IDX_W-1:0]     index;
    logic [odl_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/odl_ctrl.sv */
// Sequencing controller of the ordered delimiter locator.
// Depends on odl_pkg for the command and status structs.
module odl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  odl_pkg::t_sts i_sts,
    output odl_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_ACCEPT = 3'b001,
        S_ECHO   = 3'b010,
        S_MAP    = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_end, n_end;
    logic   take_in, take_out;

    assign take_in  = i_in_valid && (r_state == S_ACCEPT);
    assign take_out = o_out_valid && i_out_ready;

    // Handshake and command decode.
    always_comb begin
        o_in_ready         = (r_state == S_ACCEPT);
        o_out_valid        = (r_state == S_ECHO) || (r_state == S_MAP);
        o_cmd.step         = take_in;
        o_cmd.drain_start  = take_out && (r_state == S_ECHO);
        o_cmd.drain_next   = take_out && (r_state == S_MAP);
        o_cmd.show_map     = (r_state == S_MAP);
    end

    // Next state: echo every live byte, then drain the map if the scan ended.
    always_comb begin
        n_state = r_state;
        n_end   = r_end;
        unique case (r_state)
            S_ACCEPT: begin
                if (take_in && i_sts.live) begin
                    n_state = S_ECHO;
                    n_end   = i_sts.done;
                end
            end
            S_ECHO: begin
                if (take_out) begin
                    n_state = r_end ? S_MAP : S_ACCEPT;
                end
            end
            S_MAP: begin
                if (take_out && i_sts.drain_last) begin
                    n_state = S_ACCEPT;
                end
            end
            default: begin
                n_state = S_ACCEPT;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCEPT;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_end   <= n_end;
        end
    end

endmodule

/* rtl/core/odl_dp.sv */
// Datapath of the ordered delimiter locator: configuration registers, scan state,
// parallel token compare and the result register fields. Depends on odl_pkg.
module odl_dp #(
    parameter int MAX_TOKENS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  odl_pkg::t_cmd                     i_cmd,
    output odl_pkg::t_sts                     o_sts,
    input  logic                              i_cfg_we,
    input  logic [odl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [odl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [odl_pkg::BYTE_W-1:0]        i_byte_in,
    input  logic                              i_first_byte,
    output logic                              o_kind,
    output logic [odl_pkg::BYTE_W-1:0]        o_byte_out,
    output logic [odl_pkg::SLOT_W-1:0]        o_token_slot,
    output logic signed [odl_pkg::POS_W-1:0]  o_position,
    output logic [odl_pkg::LEN_W-1:0]         o_scan_length,
    output logic                              o_last
);

    localparam int IW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam logic [odl_pkg::CNT_W-1:0] MAX_N = odl_pkg::CNT_W'(MAX_TOKENS);

    // Configuration registers.
    logic [odl_pkg::CNT_W-1:0]      r_total;
    logic [odl_pkg::CFG_DATA_W-1:0] r_tokens;
    logic [odl_pkg::LEN_W-1:0]      r_limit;
    logic [odl_pkg::BYTE_W-1:0]     r_end_byte;
    logic                           r_fill;

    // Scan state.
    logic [odl_pkg::POS_W-1:0] r_slots [MAX_TOKENS];
    logic [odl_pkg::POS_W-1:0] n_slots [MAX_TOKENS];
    logic [odl_pkg::CNT_W-1:0] r_mc, n_mc;
    logic [odl_pkg::LEN_W-1:0] r_pos, n_pos;
    logic [odl_pkg::LEN_W-1:0] r_lmp, n_lmp;
    logic                      r_active, n_active;
    logic [odl_pkg::BYTE_W-1:0] r_echo, n_echo;
    logic [IW-1:0]             r_idx;

    logic [odl_pkg::CNT_W-1:0] n_tok;
    logic [IW-1:0]             top_slot;
    logic [IW-1:0]             sel;
    logic                      found;
    logic                      done;
    logic [odl_pkg::POS_W-1:0] cur_slots [MAX_TOKENS];
    logic [odl_pkg::CNT_W-1:0] cur_mc;
    logic [odl_pkg::LEN_W-1:0] cur_pos;
    logic [odl_pkg::LEN_W-1:0] cur_lmp;
    logic [odl_pkg::LEN_W-1:0] fill_val;
    logic [odl_pkg::POS_W-1:0] map_pos;

    // Number of tokens in use, clamped to 1 .. MAX_TOKENS.
    always_comb begin
        if (r_total == '0) begin
            n_tok = odl_pkg::CNT_W'(1);
        end else if (r_total > MAX_N) begin
            n_tok = MAX_N;
        end else begin
            n_tok = r_total;
        end
    end
    assign top_slot = IW'(n_tok - odl_pkg::CNT_W'(1));

    // A first byte sees the state of a fresh scan.
    always_comb begin
        for (int i = 0; i < MAX_TOKENS; i++) begin
            cur_slots[i] = i_first_byte ? odl_pkg::POS_NONE : r_slots[i];
        end
        cur_mc  = i_first_byte ? '0 : r_mc;
        cur_pos = i_first_byte ? '0 : r_pos;
        cur_lmp = i_first_byte ? '0 : r_lmp;
    end

    // Parallel compare: lowest token at or above the matched count that equals the byte.
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            if (!found && (odl_pkg::CNT_W'(i) >= cur_mc) && (odl_pkg::CNT_W'(i) < n_tok)
                && (r_tokens[8*i +: 8] == i_byte_in)) begin
                found = 1'b1;
                sel   = IW'(i);
            end
        end
    end

    // Scan step for one byte.
    always_comb begin
        n_slots  = cur_slots;
        n_mc     = cur_mc;
        n_pos    = cur_pos;
        n_lmp    = cur_lmp;
        n_echo   = i_byte_in;
        done     = 1'b0;
        if (i_byte_in == r_end_byte) begin
            done = 1'b1;
        end else if (cur_pos >= r_limit) begin
            done = 1'b1;
        end else begin
            if (found) begin
                n_slots[sel] = {1'b0, cur_pos} + odl_pkg::POS_W'(1);
                n_mc         = cur_mc + odl_pkg::CNT_W'(1);
                n_lmp        = cur_pos;
                n_echo       = '0;
            end
            if (n_slots[top_slot] != odl_pkg::POS_NONE) begin
                done = 1'b1;
            end else begin
                n_pos = cur_pos + odl_pkg::LEN_W'(1);
            end
        end
        n_active = !done;
    end

    assign o_sts.live       = i_first_byte || r_active;
    assign o_sts.done       = done;
    assign o_sts.drain_last = (r_idx == top_slot);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= odl_pkg::RST_TOKEN_TOTAL;
            r_tokens   <= '0;
            r_limit    <= odl_pkg::RST_SCAN_LIMIT;
            r_end_byte <= '0;
            r_fill     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                odl_pkg::CFG_TOKEN_TOTAL:  r_total    <= i_cfg_data[odl_pkg::CNT_W-1:0];
                odl_pkg::CFG_TOKEN_BYTES:  r_tokens   <= i_cfg_data;
                odl_pkg::CFG_SCAN_LIMIT:   r_limit    <= i_cfg_data[odl_pkg::LEN_W-1:0];
                odl_pkg::CFG_END_BYTE:     r_end_byte <= i_cfg_data[odl_pkg::BYTE_W-1:0];
                odl_pkg::CFG_FILL_MISSING: r_fill     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Scan state registers, updated when a live byte is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TOKENS; i++) begin
                r_slots[i] <= odl_pkg::POS_NONE;
            end
            r_mc     <= '0;
            r_pos    <= '0;
            r_lmp    <= '0;
            r_active <= 1'b0;
        end else if (i_cmd.step && o_sts.live) begin
            r_slots  <= n_slots;
            r_mc     <= n_mc;
            r_pos    <= n_pos;
            r_lmp    <= n_lmp;
            r_active <= n_active;
        end
    end

    // Echo byte and map index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_echo <= n_echo;
        end
        if (i_cmd.drain_start) begin
            r_idx <= '0;
        end else if (i_cmd.drain_next) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // Map entry value, with the fill for slots that never matched.
    assign fill_val = (r_lmp == '0) ? r_pos : r_lmp;
    always_comb begin
        map_pos = r_slots[r_idx];
        if ((map_pos == odl_pkg::POS_NONE) && r_fill) begin
            map_pos = {1'b0, fill_val};
        end
    end

    // Result fields.
    always_comb begin
        if (i_cmd.show_map) begin
            o_kind        = odl_pkg::KIND_MAP;
            o_byte_out    = '0;
            o_token_slot  = odl_pkg::SLOT_W'(r_idx);
            o_position    = map_pos;
            o_scan_length = r_pos;
            o_last        = (r_idx == top_slot);
        end else begin
            o_kind        = odl_pkg::KIND_ECHO;
            o_byte_out    = r_echo;
            o_token_slot  = '0;
            o_position    = '0;
            o_scan_length = '0;
            o_last        = 1'b0;
        end
    end

endmodule

/* rtl/core/ordered_delimiter_locator_top.sv */
// Top level of the ordered delimiter locator: joins controller and datapath.
// Depends on odl_pkg, the channel interfaces, odl_ctrl and odl_dp.

// The block scans a string one byte per input request and finds an ordered set of
// up to MAX_TOKENS delimiter bytes in it. Each byte of an open scan gives one echo
// result; the byte that ends a scan (terminator, scan limit, or last token found) is
// followed by one map entry per token in use (token_total held to 1 .. MAX_TOKENS).
// A byte is first taken and compared, then its echo is presented from the output
// register; the map entries follow from the slot registers, one per cycle while the
// result side is ready. Input bytes are not taken while a result is pending.
// Configuration writes are accepted in every cycle and must be made while no scan
// result is outstanding. Reset clears all scan state at once.
module ordered_delimiter_locator_top #(
    parameter int MAX_TOKENS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    odl_in_if.sink     i_in,
    odl_out_if.source  o_out,
    odl_cfg_if.sink    i_cfg
);

    odl_pkg::t_cmd cmd;
    odl_pkg::t_sts sts;

    // Configuration writes never stall.
    assign i_cfg.ready = 1'b1;

    // Request sequencing.
    odl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Compare, scan state and result fields.
    odl_dp #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_byte_in     (i_in.byte_in),
        .i_first_byte  (i_in.first_byte),
        .o_kind        (o_out.kind),
        .o_byte_out    (o_out.byte_out),
        .o_token_slot  (o_out.token_slot),
        .o_position    (o_out.position),
        .o_scan_length (o_out.scan_length),
        .o_last        (o_out.last)
    );

endmodule

/* test/tb_odl_scan_checker.sv */
`timescale 1ns / 1ps
// Scoreboard of the ordered delimiter locator testbench: it watches the byte, result and register
// channels, predicts every result with its own scan model and compares the results field by field.
// Depends on odl_pkg and the channel interfaces of odl_ifs.sv.
module odl_scan_checker #(
    parameter int MAX_TOKENS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    odl_in_if    i_in_mon,
    odl_out_if   i_out_mon,
    odl_cfg_if   i_cfg_mon,
    output int   o_fail_count,
    output int   o_waiting
);
    import odl_pkg::*;

    // One result as the block presents it.
    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   byte_out;
        logic [SLOT_W-1:0]   token_slot;
        logic [POS_W-1:0]    position;
        logic [LEN_W-1:0]    scan_length;
        logic                last;
    } t_scan_result;

    // Register copies.
    logic [CNT_W-1:0]      tok_total;
    logic [CFG_DATA_W-1:0] tok_bytes;
    logic [LEN_W-1:0]      scan_lim;
    logic [BYTE_W-1:0]     end_code;
    logic                  fill_en;

    // Scan state.
    logic [POS_W-1:0]      slot_pos [MAX_TOKENS];
    logic [CNT_W-1:0]      match_cnt;
    logic [LEN_W-1:0]      cur_offset;
    logic [LEN_W-1:0]      last_hit_pos;
    logic                  scan_live;

    t_scan_result          pending_q [$];
    int                    mismatch_cnt = 0;

    // Prints one line per mismatch and counts it.
    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_cnt++;
        $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic clear_scan();
        for (int i = 0; i < MAX_TOKENS; i++) begin
            slot_pos[i] = POS_NONE;
        end
        match_cnt    = '0;
        cur_offset   = '0;
        last_hit_pos = '0;
    endtask

    task automatic add_result(input logic kind, input logic [BYTE_W-1:0] b,
                              input logic [SLOT_W-1:0] slot, input logic [POS_W-1:0] pos,
                              input logic [LEN_W-1:0] len, input logic last);
        t_scan_result r;
        r.kind        = kind;
        r.byte_out    = b;
        r.token_slot  = slot;
        r.position    = pos;
        r.scan_length = len;
        r.last        = last;
        pending_q.push_back(r);
    endtask

    // Works out the echo and, when the scan ends, the map of one accepted byte.
    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic first);
        int               n;
        logic [BYTE_W-1:0] echo;
        logic             done;
        logic             hit;
        logic [POS_W-1:0] fill;
        logic [POS_W-1:0] p;
        n = int'(tok_total);
        if (n == 0) n = 1;
        if (n > MAX_TOKENS) n = MAX_TOKENS;
        echo = b;
        done = 1'b0;
        hit  = 1'b0;
        if (first) begin
            clear_scan();
            scan_live = 1'b1;
        end
        if (scan_live) begin
            if (b == end_code) begin
                done = 1'b1;
            end else if (cur_offset >= scan_lim) begin
                done = 1'b1;
            end else begin
                // Lowest token at or above the matched count takes the byte.
                for (int i = int'(match_cnt); i < n && !hit; i++) begin
                    if (tok_bytes[8*i +: 8] == b) begin
                        hit          = 1'b1;
                        slot_pos[i]  = {1'b0, cur_offset} + 16'd1;
                        echo         = '0;
                        match_cnt    = match_cnt + CNT_W'(1);
                        last_hit_pos = cur_offset;
                    end
                end
                if (slot_pos[n-1] != POS_NONE) done = 1'b1;
                else cur_offset = cur_offset + LEN_W'(1);
            end
            add_result(KIND_ECHO, echo, '0, '0, '0, 1'b0);
            if (done) begin
                scan_live = 1'b0;
                fill = (last_hit_pos == '0) ? {1'b0, cur_offset} : {1'b0, last_hit_pos};
                for (int i = 0; i < n; i++) begin
                    p = slot_pos[i];
                    if (p == POS_NONE && fill_en) p = fill;
                    add_result(KIND_MAP, '0, SLOT_W'(i), p, cur_offset, (i + 1 == n));
                end
            end
        end
    endtask

    task automatic check_result();
        t_scan_result want;
        if (pending_q.size() == 0) begin
            flag_mismatch("unexpected result", 64'({i_out_mon.kind, i_out_mon.byte_out}), '0);
        end else begin
            want = pending_q.pop_front();
            if (i_out_mon.kind != want.kind)
                flag_mismatch("kind", 64'(i_out_mon.kind), 64'(want.kind));
            if (i_out_mon.byte_out != want.byte_out)
                flag_mismatch("byte_out", 64'(i_out_mon.byte_out), 64'(want.byte_out));
            if (i_out_mon.token_slot != want.token_slot)
                flag_mismatch("token_slot", 64'(i_out_mon.token_slot), 64'(want.token_slot));
            if (i_out_mon.position != want.position)
                flag_mismatch("position", 64'(i_out_mon.position), 64'(want.position));
            if (i_out_mon.scan_length != want.scan_length)
                flag_mismatch("scan_length", 64'(i_out_mon.scan_length),
                              64'(want.scan_length));
            if (i_out_mon.last != want.last)
                flag_mismatch("last", 64'(i_out_mon.last), 64'(want.last));
        end
    endtask

    // All three channels are sampled at the same edge the block sees them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tok_total = RST_TOKEN_TOTAL;
            tok_bytes = '0;
            scan_lim  = RST_SCAN_LIMIT;
            end_code  = '0;
            fill_en   = 1'b0;
            clear_scan();
            scan_live = 1'b0;
            pending_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) check_result();
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (i_cfg_mon.index)
                    CFG_TOKEN_TOTAL:  tok_total = i_cfg_mon.data[CNT_W-1:0];
                    CFG_TOKEN_BYTES:  tok_bytes = i_cfg_mon.data;
                    CFG_SCAN_LIMIT:   scan_lim  = i_cfg_mon.data[LEN_W-1:0];
                    CFG_END_BYTE:     end_code  = i_cfg_mon.data[BYTE_W-1:0];
                    CFG_FILL_MISSING: fill_en   = i_cfg_mon.data[0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready)
                predict_byte(i_in_mon.byte_in, i_in_mon.first_byte);
        end
        o_waiting    <= pending_q.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

/* test/tb_ordered_delimiter_locator_top.sv */
`timescale 1ns / 1ps
// Testbench top of the ordered delimiter locator: clock, reset, byte and register stimulus and
// random result-side stalls. Depends on odl_pkg, odl_ifs.sv, the block and odl_scan_checker.
module tb_ordered_delimiter_locator_top;
    import odl_pkg::*;

    localparam int MAX_TOKENS   = 8;
    localparam int RANDOM_ITEMS = 200;
    localparam int CALM_ITEMS   = 40;
    localparam int RX_HOLD      = 150;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 300000;
    // An index outside the register map; the block is expected to drop such writes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    odl_in_if  in_ch ();
    odl_out_if out_ch ();
    odl_cfg_if cfg_ch ();

    int fail_count;
    int waiting;
    int cycle_cnt = 0;

    // Stimulus-side view of the settings in force.
    logic [CFG_DATA_W-1:0] tok_shadow;
    logic [BYTE_W-1:0]     end_shadow;
    int                    tok_count;

    int items_sent = 0;
    bit calm = 1'b0;
    bit hold_asked = 1'b0;
    int tx_gap_pct = 0;
    int rx_gap_pct = 0;

    ordered_delimiter_locator_top #(
        .MAX_TOKENS(MAX_TOKENS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    odl_scan_checker #(
        .MAX_TOKENS(MAX_TOKENS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .i_out_mon    (out_ch),
        .i_cfg_mon    (cfg_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_ordered_delimiter_locator_top failed");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off when asked.
    initial begin : rx_side
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (hold_asked) begin
                hold_asked = 1'b0;
                stall_left = RX_HOLD;
            end else if (!calm && $urandom_range(1, 100) <= rx_gap_pct) begin
                stall_left = $urandom_range(1, 18);
            end
            out_ch.ready <= (stall_left == 0);
        end
    end

    // Offers one byte request, maybe after a gap, and returns at the edge that takes it.
    // Valid is left high so that a following request continues without a bubble.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first);
        if (!calm && $urandom_range(1, 100) <= tx_gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_in    <= b;
        in_ch.first_byte <= first;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Waits until every predicted result has come out, then lets the block settle.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Writes every register; only called while the block is idle.
    task automatic apply_settings(input logic [CNT_W-1:0] total, input logic [CFG_DATA_W-1:0] toks,
                                  input logic [LEN_W-1:0] lim, input logic [BYTE_W-1:0] endb,
                                  input logic fill, input bit spare);
        if (spare) write_reg(CFG_SPARE, {$urandom, $urandom});
        write_reg(CFG_TOKEN_TOTAL, CFG_DATA_W'(total));
        write_reg(CFG_TOKEN_BYTES, toks);
        write_reg(CFG_SCAN_LIMIT, CFG_DATA_W'(lim));
        write_reg(CFG_END_BYTE, CFG_DATA_W'(endb));
        write_reg(CFG_FILL_MISSING, CFG_DATA_W'(fill));
        cfg_ch.valid <= 1'b0;
        tok_shadow = toks;
        end_shadow = endb;
        tok_count  = (total == 0) ? 1 : ((total > MAX_TOKENS) ? MAX_TOKENS : int'(total));
    endtask

    // One scan: mostly tokens in their own order, with stray bytes, terminators and restarts.
    task automatic random_scan(input int len);
        int               nxt;
        int               pick;
        int               slot;
        logic [BYTE_W-1:0] b;
        nxt = 0;
        b = ($urandom_range(0, 2) == 0) ? tok_shadow[7:0] : BYTE_W'($urandom);
        send_byte(b, 1'b1);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                slot = nxt % tok_count;
                nxt++;
                send_byte(tok_shadow[8*slot +: 8], 1'b0);
            end else if (pick < 55) begin
                slot = $urandom_range(0, tok_count - 1);
                send_byte(tok_shadow[8*slot +: 8], 1'b0);
            end else if (pick < 60) begin
                send_byte(end_shadow, 1'b0);
            end else if (pick < 64) begin
                send_byte(BYTE_W'($urandom), 1'b1);
            end else begin
                send_byte(BYTE_W'($urandom), 1'b0);
            end
        end
    endtask

    initial begin : stimulus
        int               target;
        int               phase;
        int               phase_end;
        logic [CNT_W-1:0] total;
        logic [CFG_DATA_W-1:0] toks;
        logic [LEN_W-1:0] lim;

        in_ch.valid      = 1'b0;
        in_ch.byte_in    = '0;
        in_ch.first_byte = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        tok_shadow       = '0;
        end_shadow       = '0;
        tok_count        = MAX_TOKENS;
        i_rst_n          = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a byte with no scan open is dropped, and the zero terminator
        // ends a new scan at once with every slot empty.
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();

        // Three tokens A, B, C with fill on: the last slot ends the scan early and the
        // skipped first slot takes the last match position.
        apply_settings(4'd3, 64'h0000_0000_0043_4241, 15'd4, 8'hFF, 1'b1, 1'b1);
        send_byte("x", 1'b1);
        send_byte("B", 1'b0);
        send_byte("A", 1'b0);
        send_byte("C", 1'b0);
        // A restart drops the open scan; the new one runs into the scan limit.
        send_byte("A", 1'b1);
        send_byte("z", 1'b0);
        send_byte("A", 1'b1);
        repeat (4) send_byte("z", 1'b0);
        wait_drained();

        // The same token matched twice overwrites its slot; the terminator ends the scan.
        apply_settings(4'd3, 64'h0000_0000_0043_4241, 15'd15, 8'hFF, 1'b0, 1'b0);
        send_byte("B", 1'b1);
        send_byte("B", 1'b0);
        send_byte("A", 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_drained();

        // Token count zero acts as one; a zero scan limit ends on the first byte.
        apply_settings(4'd0, 64'hFFFF_FFFF_FFFF_FF80, 15'd0, 8'h7F, 1'b0, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_drained();

        // Token count above the maximum acts as the maximum; all eight slots fill in order.
        apply_settings(4'd15, 64'hF0E1_D2C3_B4A5_9687, 15'h7FFF, 8'h00, 1'b1, 1'b0);
        for (int i = 0; i < MAX_TOKENS; i++) begin
            send_byte(8'h87 + 8'(i) * 8'h0F, (i == 0));
        end
        wait_drained();

        // Random phases, each with its own settings and idling mix.
        target = items_sent + RANDOM_ITEMS;
        phase  = 0;
        while (items_sent < target) begin
            calm = (target - items_sent) <= CALM_ITEMS;
            case ($urandom_range(0, 2))
                0:       tx_gap_pct = 0;
                1:       tx_gap_pct = 10;
                default: tx_gap_pct = 30;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_gap_pct = 0;
                1:       rx_gap_pct = 10;
                default: rx_gap_pct = 30;
            endcase
            case ($urandom_range(0, 5))
                0:       total = 4'd0;
                1:       total = 4'd1;
                2:       total = 4'd8;
                3:       total = 4'($urandom_range(9, 15));
                default: total = 4'($urandom_range(1, 8));
            endcase
            toks = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) toks[15:8] = toks[7:0];
            case ($urandom_range(0, 5))
                0:       lim = 15'd0;
                1:       lim = 15'h7FFF;
                2:       lim = 15'($urandom_range(1, 3));
                default: lim = 15'($urandom_range(4, 24));
            endcase
            apply_settings(total, toks, lim, BYTE_W'($urandom), 1'($urandom_range(0, 1)), 1'b0);

            // Once, the result side holds off while bytes keep coming.
            if (phase == 1) hold_asked = 1'b1;

            phase_end = items_sent + $urandom_range(20, 40);
            while (items_sent < phase_end && items_sent < target) begin
                // The last stretch of the run goes without idling.
                calm = (target - items_sent) <= CALM_ITEMS;
                random_scan($urandom_range(0, 14));
            end
            // Close any scan still open before the settings change.
            send_byte(end_shadow, 1'b0);
            wait_drained();
            phase++;
        end

        if (fail_count == 0 && waiting == 0) begin
            $display("tb_ordered_delimiter_locator_top passed");
        end else begin
            $display("tb_ordered_delimiter_locator_top failed");
        end
        $finish;
    end

endmodule
